// ===== rtl/gpbs_pkg.sv =====
// shared types, constants and codes for the gated point bin statistics block
package gpbs_pkg;

  // binning geometry and counter size
  localparam int NUM_BINS     = 100;
  localparam int BIN_WIDTH_MM = 100;
  localparam int COUNT_BITS   = 16;

  localparam int BIN_IDX_W = $clog2(NUM_BINS + 1);
  localparam int RAM_AW    = $clog2(NUM_BINS);

  // reciprocal of the bin width for the bin index estimate
  localparam int RECIP_SHIFT = 24;
  localparam int RECIP_W     = RECIP_SHIFT + 1;
  localparam logic [RECIP_W-1:0] BIN_RECIP = RECIP_W'((1 << RECIP_SHIFT) / BIN_WIDTH_MM);
  localparam int QEST_W = 15;
  localparam int REM_W  = 28;

  // rounded fit error width
  localparam int ERR_W = 22;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  // result status codes
  localparam logic [1:0] ST_REJECT = 2'd0;
  localparam logic [1:0] ST_BINNED = 2'd1;
  localparam logic [1:0] ST_TOTAL  = 2'd2;
  localparam logic [1:0] ST_READ   = 2'd3;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Z_LIMIT   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_NEAR    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_X_FAR     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_ICPT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_SLOPE = 3'd5;

  // configuration reset values
  localparam logic [14:0] Y_LIMIT_RST = 15'd50;
  localparam logic [15:0] Z_LIMIT_RST = 16'd500;
  localparam logic [15:0] X_NEAR_RST  = 16'd0;
  localparam logic [15:0] X_FAR_RST   = 16'd10000;
  localparam logic [15:0] FIT_RST     = 16'd0;

  // one store entry: a bin or the totals
  typedef struct packed {
    logic [COUNT_BITS-1:0] count;
    logic [39:0]           sum_x;
    logic [39:0]           sum_y;
    logic [39:0]           sum_z;
    logic [31:0]           sum_int;
    logic [39:0]           sum_err;
    logic [47:0]           sum_zz;
    logic [47:0]           sum_xx;
    logic [47:0]           sum_xz;
  } entry_t;

  // captured request
  typedef struct packed {
    logic        mode;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] pos_z;
    logic [7:0]  intensity;
    logic [6:0]  read_index;
  } req_t;

  // configuration registers
  typedef struct packed {
    logic [14:0] y_limit;
    logic [15:0] z_limit;
    logic [15:0] x_near;
    logic [15:0] x_far;
    logic [15:0] fit_intercept;
    logic [15:0] fit_slope;
  } cfg_t;

  // stage enables from the sequencer to the point datapath
  typedef struct packed {
    logic prod;
    logic bin;
    logic err;
  } stage_en_t;

  // per point terms handed to the update step
  typedef struct packed {
    logic                 gated;
    logic                 has_bin;
    logic [BIN_IDX_W-1:0] bin;
    logic [31:0]          xx;
    logic [31:0]          zz;
    logic [31:0]          xz;
    logic [ERR_W-1:0]     err;
  } pt_t;

endpackage

// ===== rtl/gpbs_bin_ram.sv =====
// bin store: synchronous memory with per entry valid bits cleared at reset
module gpbs_bin_ram (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [gpbs_pkg::RAM_AW-1:0]   rd_addr,
  output gpbs_pkg::entry_t              rd_data,
  input  logic                          wr_en,
  input  logic [gpbs_pkg::RAM_AW-1:0]   wr_addr,
  input  gpbs_pkg::entry_t              wr_data
);

  gpbs_pkg::entry_t                    mem [gpbs_pkg::NUM_BINS];
  logic [gpbs_pkg::NUM_BINS-1:0]       valid_r;
  gpbs_pkg::entry_t                    rd_data_r;
  logic                                rd_vld_r;

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // valid bits, an entry never written reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_vld_r ? rd_data_r : '0;

endmodule

// ===== rtl/gpbs_point_calc.sv =====
// point datapath: gate, products, bin index and rounded fit error over three steps
module gpbs_point_calc (
  input  logic                clk,
  input  gpbs_pkg::stage_en_t en,
  input  gpbs_pkg::req_t      req,
  input  gpbs_pkg::cfg_t      cfg,
  output gpbs_pkg::pt_t       pt
);

  logic                          gated_r;
  logic [31:0]                   xx_r;
  logic [31:0]                   zz_r;
  logic [31:0]                   xz_r;
  logic signed [31:0]            fsx_r;
  logic [gpbs_pkg::QEST_W-1:0]   q_est_r;
  logic                          has_bin_r;
  logic [gpbs_pkg::BIN_IDX_W-1:0] bin_r;
  logic signed [33:0]            d_r;
  logic [gpbs_pkg::ERR_W-1:0]    err_r;

  logic signed [16:0]            y_ext;
  logic signed [16:0]            ylim_ext;
  logic                          gate_c;
  logic signed [31:0]            xx_s;
  logic signed [31:0]            zz_s;
  logic signed [31:0]            xz_s;
  logic signed [31:0]            fsx_s;
  logic [39:0]                   qprod;

  logic [gpbs_pkg::REM_W-1:0]    qw;
  logic [gpbs_pkg::REM_W-1:0]    rem;
  logic [gpbs_pkg::REM_W-1:0]    rem_fix;
  logic [15:0]                   q_fix;
  logic                          has_bin_c;
  logic signed [16:0]            zdiff;
  logic signed [33:0]            d_c;

  logic [33:0]                   mag;
  logic [33:0]                   rnd;

  // box gate
  always_comb begin
    y_ext    = $signed({req.pos_y[15], req.pos_y});
    ylim_ext = $signed({2'b00, cfg.y_limit});
    gate_c   = (y_ext > -ylim_ext) && (y_ext < ylim_ext) && (req.pos_y != 16'd0) &&
               (req.pos_z != 16'd0) && ($signed(req.pos_z) < $signed(cfg.z_limit)) &&
               ($signed(req.pos_x) > $signed(cfg.x_near)) &&
               ($signed(req.pos_x) < $signed(cfg.x_far));
  end

  // products and bin quotient estimate
  assign xx_s  = $signed(req.pos_x) * $signed(req.pos_x);
  assign zz_s  = $signed(req.pos_z) * $signed(req.pos_z);
  assign xz_s  = $signed(req.pos_x) * $signed(req.pos_z);
  assign fsx_s = $signed(cfg.fit_slope) * $signed(req.pos_x);
  assign qprod = 40'(req.pos_x[14:0]) * 40'(gpbs_pkg::BIN_RECIP);

  always_ff @(posedge clk) begin
    if (en.prod) begin
      gated_r <= gate_c;
      xx_r    <= xx_s;
      zz_r    <= zz_s;
      xz_r    <= xz_s;
      fsx_r   <= fsx_s;
      q_est_r <= qprod[gpbs_pkg::RECIP_SHIFT +: gpbs_pkg::QEST_W];
    end
  end

  // quotient correction and signed distance to the reference line
  always_comb begin
    qw  = gpbs_pkg::REM_W'(q_est_r) * gpbs_pkg::REM_W'(gpbs_pkg::BIN_WIDTH_MM);
    rem = gpbs_pkg::REM_W'(req.pos_x[14:0]) - qw;
    if (rem >= gpbs_pkg::REM_W'(gpbs_pkg::BIN_WIDTH_MM)) begin
      q_fix   = 16'(q_est_r) + 16'd1;
      rem_fix = rem - gpbs_pkg::REM_W'(gpbs_pkg::BIN_WIDTH_MM);
    end else begin
      q_fix   = 16'(q_est_r);
      rem_fix = rem;
    end
    has_bin_c = !req.pos_x[15] && (req.pos_x != 16'd0) && (rem_fix != '0) &&
                (q_fix < 16'(gpbs_pkg::NUM_BINS));
    zdiff = $signed({req.pos_z[15], req.pos_z}) -
            $signed({cfg.fit_intercept[15], cfg.fit_intercept});
    d_c   = $signed({{5{zdiff[16]}}, zdiff, 12'd0}) - $signed({{2{fsx_r[31]}}, fsx_r});
  end

  always_ff @(posedge clk) begin
    if (en.bin) begin
      has_bin_r <= has_bin_c;
      bin_r     <= q_fix[gpbs_pkg::BIN_IDX_W-1:0];
      d_r       <= d_c;
    end
  end

  // absolute error rounded to mm
  assign mag = d_r[33] ? (34'd0 - d_r) : d_r;
  assign rnd = mag + 34'd2048;

  always_ff @(posedge clk) begin
    if (en.err) begin
      err_r <= rnd[12 +: gpbs_pkg::ERR_W];
    end
  end

  always_comb begin
    pt.gated   = gated_r;
    pt.has_bin = has_bin_r;
    pt.bin     = bin_r;
    pt.xx      = xx_r;
    pt.zz      = zz_r;
    pt.xz      = xz_r;
    pt.err     = err_r;
  end

endmodule

// ===== rtl/gated_point_bin_statistics.sv =====
// top level: request sequencer, totals, bin read-modify-write and result register
// result: the result register and its strobe are loaded from the update step
// requests: one at a time, a new request is taken only in idle after the four-step
//   sequence through the bin memory (gate/products, bin index, read, update)
// reset: configuration to defaults, totals and all bin valid bits cleared; no clearing
//   pass, requests are taken right after reset; the receiver cannot stall
module gated_point_bin_statistics (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic signed [15:0] in_pos_z,
  input  logic [7:0]         in_intensity,
  input  logic [6:0]         in_read_index,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [6:0]         out_bin_index,
  output logic [15:0]        out_point_count,
  output logic [39:0]        out_sum_x,
  output logic signed [39:0] out_sum_y,
  output logic signed [39:0] out_sum_z,
  output logic [31:0]        out_sum_inten,
  output logic [39:0]        out_sum_error,
  output logic [47:0]        out_sum_zz,
  output logic [47:0]        out_sum_xx,
  output logic signed [47:0] out_sum_xz,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PROD = 3'd1;
  localparam logic [2:0] S_BIN  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_UPD  = 3'd4;

  logic [2:0]            state_r;
  logic [2:0]            state_nxt;
  gpbs_pkg::req_t        req_r;
  gpbs_pkg::cfg_t        cfg_r;
  gpbs_pkg::entry_t      tot_r;
  gpbs_pkg::stage_en_t   stage_en;
  gpbs_pkg::pt_t         pt;

  logic                          accept;
  logic                          rd_is_bin;
  logic                          rd_use;
  logic                          rd_en;
  logic [gpbs_pkg::RAM_AW-1:0]   rd_addr;
  gpbs_pkg::entry_t              rd_data;
  logic                          wr_en;
  gpbs_pkg::entry_t              bin_new;
  gpbs_pkg::entry_t              tot_new;
  logic                          tot_full;
  logic                          bin_full;
  logic                          tot_upd;

  logic [39:0] ux40;
  logic [39:0] uy40;
  logic [39:0] uz40;
  logic [31:0] int32;
  logic [39:0] err40;
  logic [47:0] xx48;
  logic [47:0] zz48;
  logic [47:0] xz48;

  logic [1:0]                     res_status;
  logic [gpbs_pkg::BIN_IDX_W-1:0] res_idx;
  gpbs_pkg::entry_t               res_ent;

  logic                           out_valid_r;
  logic [1:0]                     out_status_r;
  logic [gpbs_pkg::BIN_IDX_W-1:0] out_idx_r;
  gpbs_pkg::entry_t               out_ent_r;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (accept) state_nxt = S_PROD;
      S_PROD: state_nxt = S_BIN;
      S_BIN:  state_nxt = S_READ;
      S_READ: state_nxt = S_UPD;
      S_UPD:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r.mode       <= in_mode;
      req_r.pos_x      <= in_pos_x;
      req_r.pos_y      <= in_pos_y;
      req_r.pos_z      <= in_pos_z;
      req_r.intensity  <= in_intensity;
      req_r.read_index <= in_read_index;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.y_limit       <= gpbs_pkg::Y_LIMIT_RST;
      cfg_r.z_limit       <= gpbs_pkg::Z_LIMIT_RST;
      cfg_r.x_near        <= gpbs_pkg::X_NEAR_RST;
      cfg_r.x_far         <= gpbs_pkg::X_FAR_RST;
      cfg_r.fit_intercept <= gpbs_pkg::FIT_RST;
      cfg_r.fit_slope     <= gpbs_pkg::FIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gpbs_pkg::CFG_Y_LIMIT:   cfg_r.y_limit       <= cfg_data[14:0];
        gpbs_pkg::CFG_Z_LIMIT:   cfg_r.z_limit       <= cfg_data;
        gpbs_pkg::CFG_X_NEAR:    cfg_r.x_near        <= cfg_data;
        gpbs_pkg::CFG_X_FAR:     cfg_r.x_far         <= cfg_data;
        gpbs_pkg::CFG_FIT_ICPT:  cfg_r.fit_intercept <= cfg_data;
        gpbs_pkg::CFG_FIT_SLOPE: cfg_r.fit_slope     <= cfg_data;
        default: ;
      endcase
    end
  end

  // point datapath
  assign stage_en.prod = (state_r == S_PROD);
  assign stage_en.bin  = (state_r == S_BIN);
  assign stage_en.err  = (state_r == S_READ);

  gpbs_point_calc u_calc (
    .clk (clk),
    .en  (stage_en),
    .req (req_r),
    .cfg (cfg_r),
    .pt  (pt)
  );

  // bin memory read, one request in flight so no same-entry overlap
  assign rd_is_bin = (req_r.read_index < 7'(gpbs_pkg::NUM_BINS));
  assign rd_use    = req_r.mode ? rd_is_bin : (pt.gated && pt.has_bin);
  assign rd_en     = (state_r == S_READ) && rd_use;
  assign rd_addr   = req_r.mode ? req_r.read_index[gpbs_pkg::RAM_AW-1:0]
                                : pt.bin[gpbs_pkg::RAM_AW-1:0];

  gpbs_bin_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (pt.bin[gpbs_pkg::RAM_AW-1:0]),
    .wr_data (bin_new)
  );

  // accumulation operands
  always_comb begin
    ux40  = {{24{req_r.pos_x[15]}}, req_r.pos_x};
    uy40  = {{24{req_r.pos_y[15]}}, req_r.pos_y};
    uz40  = {{24{req_r.pos_z[15]}}, req_r.pos_z};
    int32 = {24'd0, req_r.intensity};
    err40 = {{(40 - gpbs_pkg::ERR_W){1'b0}}, pt.err};
    xx48  = {16'd0, pt.xx};
    zz48  = {16'd0, pt.zz};
    xz48  = {{16{pt.xz[31]}}, pt.xz};
  end

  // updated totals and bin entries
  always_comb begin
    tot_full        = (tot_r.count == gpbs_pkg::COUNT_MAX);
    tot_new         = tot_r;
    tot_new.count   = tot_r.count + 1'b1;
    tot_new.sum_x   = tot_r.sum_x + ux40;
    tot_new.sum_z   = tot_r.sum_z + uz40;
    tot_new.sum_zz  = tot_r.sum_zz + zz48;
    tot_new.sum_xx  = tot_r.sum_xx + xx48;
    tot_new.sum_xz  = tot_r.sum_xz + xz48;

    bin_full        = (rd_data.count == gpbs_pkg::COUNT_MAX);
    bin_new.count   = rd_data.count + 1'b1;
    bin_new.sum_x   = rd_data.sum_x + ux40;
    bin_new.sum_y   = rd_data.sum_y + uy40;
    bin_new.sum_z   = rd_data.sum_z + uz40;
    bin_new.sum_int = rd_data.sum_int + int32;
    bin_new.sum_err = rd_data.sum_err + err40;
    bin_new.sum_zz  = rd_data.sum_zz + zz48;
    bin_new.sum_xx  = rd_data.sum_xx + xx48;
    bin_new.sum_xz  = rd_data.sum_xz + xz48;
  end

  assign tot_upd = (state_r == S_UPD) && !req_r.mode && pt.gated && !tot_full;
  assign wr_en   = (state_r == S_UPD) && !req_r.mode && pt.gated && pt.has_bin && !bin_full;

  // totals store, sums of y, intensity and error stay zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tot_r <= '0;
    end else if (tot_upd) begin
      tot_r <= tot_new;
    end
  end

  // result selection
  always_comb begin
    priority if (req_r.mode) begin
      res_status = gpbs_pkg::ST_READ;
      res_idx    = rd_is_bin ? req_r.read_index : gpbs_pkg::BIN_IDX_W'(gpbs_pkg::NUM_BINS);
      res_ent    = rd_is_bin ? rd_data : tot_r;
    end else if (!pt.gated) begin
      res_status = gpbs_pkg::ST_REJECT;
      res_idx    = '0;
      res_ent    = '0;
    end else if (pt.has_bin) begin
      res_idx    = pt.bin;
      res_status = bin_full ? gpbs_pkg::ST_TOTAL : gpbs_pkg::ST_BINNED;
      res_ent    = bin_full ? rd_data : bin_new;
    end else begin
      res_status = gpbs_pkg::ST_TOTAL;
      res_idx    = gpbs_pkg::BIN_IDX_W'(gpbs_pkg::NUM_BINS);
      res_ent    = tot_full ? tot_r : tot_new;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (state_r == S_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_UPD) begin
      out_status_r <= res_status;
      out_idx_r    <= res_idx;
      out_ent_r    <= res_ent;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_bin_index     = out_idx_r;
  assign out_point_count   = out_ent_r.count;
  assign out_sum_x         = out_ent_r.sum_x;
  assign out_sum_y         = $signed(out_ent_r.sum_y);
  assign out_sum_z         = $signed(out_ent_r.sum_z);
  assign out_sum_inten     = out_ent_r.sum_int;
  assign out_sum_error     = out_ent_r.sum_err;
  assign out_sum_zz        = out_ent_r.sum_zz;
  assign out_sum_xx        = out_ent_r.sum_xx;
  assign out_sum_xz        = $signed(out_ent_r.sum_xz);

endmodule

// ===== rtl/gpbs_checker.sv =====
// port level checks for the gated point bin statistics block and their binding
module gpbs_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [1:0]  out_status,
  input logic [6:0]  out_bin_index,
  input logic [15:0] out_point_count,
  input logic [39:0] out_sum_x
);

  // an accepted request keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // the result strobe comes once the sequence has finished
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  // a rejected point reports nothing
  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == gpbs_pkg::ST_REJECT) |->
      (out_bin_index == 7'd0) && (out_point_count == 16'd0) && (out_sum_x == 40'd0))
    else $error("rejected point with nonzero result");

  // a binned point lands in a real bin that now holds it
  a_binned: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == gpbs_pkg::ST_BINNED) |->
      (out_point_count != 16'd0) && (out_bin_index < 7'(gpbs_pkg::NUM_BINS)))
    else $error("binned result outside the bins or empty");

  // totals-only result is either the totals entry or a full bin
  a_total_only: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == gpbs_pkg::ST_TOTAL) |->
      (out_bin_index == 7'(gpbs_pkg::NUM_BINS)) ||
      (out_point_count == gpbs_pkg::COUNT_MAX))
    else $error("totals-only result neither totals nor a full bin");

endmodule

bind gated_point_bin_statistics gpbs_checker u_gpbs_checker (.*);
